// File: rtl/epq_pkg.sv
// shared constants and types of the expiring play queue
// no dependencies; imported by every module of the block
`default_nettype none

package epq_pkg;

  localparam int unsigned QUEUE_SLOTS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF   = 48;

  localparam int unsigned LIFETIME_W = 24;
  localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 24'd1966080;  // 30.0 s in 8.16

  localparam int unsigned SOUND_W = 8;
  localparam int unsigned COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam int unsigned MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQUEUE = 3'd0,
    MODE_PROCESS = 3'd1,
    MODE_PAUSE   = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_REPORT  = 3'd4
  } mode_e;

endpackage

`default_nettype wire

// File: rtl/epq_store.sv
// entry memory of the play queue: enqueue time and sound number per slot
// one write port, one registered read port; uses epq_pkg
`default_nettype none

module epq_store
  import epq_pkg::*;
#(
  parameter int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  localparam int unsigned AW = $clog2(QUEUE_SLOTS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic [TIME_BITS-1:0] wr_time_i,
  input  wire logic [SOUND_W-1:0]   wr_sound_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [TIME_BITS-1:0] rd_time_o,
  output logic      [SOUND_W-1:0]   rd_sound_o
);

  logic [TIME_BITS-1:0] time_mem  [QUEUE_SLOTS];
  logic [SOUND_W-1:0]   sound_mem [QUEUE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i]  <= wr_time_i;
      sound_mem[wr_addr_i] <= wr_sound_i;
    end
    rd_time_o  <= time_mem[rd_addr_i];
    rd_sound_o <= sound_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/epq_expiry.sv
// shared expiry unit: adds lifetime to an entry time, then compares with now
// add into a register, then compare the registered sum with now; uses epq_pkg
`default_nettype none

module epq_expiry
  import epq_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  load_i,
  input  wire logic [TIME_BITS-1:0]  entry_time_i,
  input  wire logic [LIFETIME_W-1:0] lifetime_i,
  input  wire logic [TIME_BITS-1:0]  now_i,
  output logic                       live_o
);

  // one extra bit keeps the carry: a carried sum is always in the future
  logic [TIME_BITS:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= {1'b0, entry_time_i} + (TIME_BITS+1)'(lifetime_i);
    end
  end

  assign live_o = sum_q[TIME_BITS] || (sum_q[TIME_BITS-1:0] > now_i);

endmodule

`default_nettype wire

// File: rtl/expiring_play_queue_top.sv
// expiring play queue: circular request queue with time-to-live expiry
// sequence: pause, clear, start report and unused modes answer in the cycle after start;
//   enqueue/process: mark check, then head read, add, compare, ending at an offer, an empty
//   queue or a still-playing head; each expired pop (at most QUEUE_SLOTS-1) repeats them
// throughput: one word at a time, busy_o high until the result strobe; no receiver stall
// reset: asynchronous active low, empties the queue and reloads lifetime to 30 s
`default_nettype none

module expiring_play_queue_top
  import epq_pkg::*;
#(
  parameter int unsigned QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command side
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [MODE_W-1:0]     mode_i,
  input  wire logic [SOUND_W-1:0]    sound_number_i,
  input  wire logic [TIME_BITS-1:0]  now_time_i,
  input  wire logic                  channel_busy_i,
  input  wire logic                  start_accepted_i,
  // lifetime register write
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LIFETIME_W-1:0] cfg_lifetime_i,
  // result side
  output logic                       done_o,
  output logic                       start_request_o,
  output logic [SOUND_W-1:0]         start_sound_o,
  output logic                       dropped_full_o,
  output logic [COUNT_W-1:0]         expired_count_o,
  output logic [COUNT_W-1:0]         queue_count_o,
  output logic                       head_playing_o
);

  localparam int unsigned AW = $clog2(QUEUE_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_SLOTS - 1);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for a word
    S_PROC = 5'b00010,  // playing-mark check and finished-sound pop
    S_HEAD = 5'b00100,  // empty check, memory reads the head slot
    S_ADD  = 5'b01000,  // expiry unit forms time plus lifetime
    S_CMP  = 5'b10000   // compare with now: offer or pop expired
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        tail_q, tail_d;
  logic [AW-1:0]        total_q, total_d;
  logic [AW-1:0]        exp_q, exp_d;
  logic                 playing_q, playing_d;
  logic                 drop_q, drop_d;
  logic                 chbusy_q, chbusy_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [LIFETIME_W-1:0] lifetime_q;

  // result registers
  logic                 done_q;
  logic                 req_q;
  logic [SOUND_W-1:0]   snd_q;
  logic                 dropped_q;
  logic [COUNT_W-1:0]   expcnt_q;
  logic [COUNT_W-1:0]   qcnt_q;
  logic                 play_out_q;

  logic                 fin;
  logic                 offer;
  logic                 wr_en;
  logic                 load;
  logic                 live;
  logic [TIME_BITS-1:0] rd_time;
  logic [SOUND_W-1:0]   rd_sound;
  logic [AW-1:0]        tail_nxt;
  logic [AW-1:0]        head_nxt;
  logic                 empty;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [AW-1:0] v);
    return (32'(v) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(v);
  endfunction

  assign tail_nxt = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
  assign head_nxt = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
  assign empty    = (head_q == tail_q);

  // entry memory, read port always follows the head
  epq_store #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_time_i (now_time_i),
    .wr_sound_i(sound_number_i),
    .rd_addr_i (head_q),
    .rd_time_o (rd_time),
    .rd_sound_o(rd_sound)
  );

  // one adder and comparator, reused for every head entry checked
  epq_expiry #(
    .TIME_BITS(TIME_BITS)
  ) u_expiry (
    .clk_i       (clk_i),
    .load_i      (load),
    .entry_time_i(rd_time),
    .lifetime_i  (lifetime_q),
    .now_i       (now_q),
    .live_o      (live)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    total_d   = total_q;
    exp_d     = exp_q;
    playing_d = playing_q;
    drop_d    = drop_q;
    chbusy_d  = chbusy_q;
    now_d     = now_q;
    fin       = 1'b0;
    offer     = 1'b0;
    wr_en     = 1'b0;
    load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          now_d    = now_time_i;
          chbusy_d = channel_busy_i;
          exp_d    = '0;
          drop_d   = 1'b0;
          case (mode_i)
            MODE_ENQUEUE: begin
              // one slot stays empty, so next tail on head means full
              if (tail_nxt == head_q) begin
                drop_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                tail_d  = tail_nxt;
                total_d = total_q + AW'(1);
              end
              state_d = S_PROC;
            end
            MODE_PROCESS: begin
              state_d = S_PROC;
            end
            MODE_PAUSE: begin
              playing_d = 1'b0;
              fin       = 1'b1;
            end
            MODE_CLEAR: begin
              head_d    = '0;
              tail_d    = '0;
              total_d   = '0;
              playing_d = 1'b0;
              fin       = 1'b1;
            end
            MODE_REPORT: begin
              playing_d = start_accepted_i && !empty;
              fin       = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PROC: begin
        if (playing_q) begin
          if (chbusy_q && !empty) begin
            // head sound still playing, nothing to do
            fin     = 1'b1;
            state_d = S_IDLE;
          end else begin
            // finished sound leaves the queue
            if (!empty) begin
              head_d  = head_nxt;
              total_d = total_q - AW'(1);
            end
            playing_d = 1'b0;
            state_d   = S_HEAD;
          end
        end else begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (empty) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        load    = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (live) begin
          offer   = 1'b1;
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          // expired: pop and check the new head
          head_d  = head_nxt;
          total_d = total_q - AW'(1);
          exp_d   = exp_q + AW'(1);
          state_d = S_HEAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      total_q    <= '0;
      exp_q      <= '0;
      playing_q  <= 1'b0;
      drop_q     <= 1'b0;
      chbusy_q   <= 1'b0;
      lifetime_q <= LIFETIME_RESET;
      done_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      total_q   <= total_d;
      exp_q     <= exp_d;
      playing_q <= playing_d;
      drop_q    <= drop_d;
      chbusy_q  <= chbusy_d;
      done_q    <= fin;
      if (cfg_valid_i && cfg_ready_o) begin
        lifetime_q <= cfg_lifetime_i;
      end
    end
  end

  // payload registers, loaded with the state the word leaves behind
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (fin) begin
      req_q      <= offer;
      snd_q      <= offer ? rd_sound : '0;
      dropped_q  <= drop_d;
      expcnt_q   <= sat_count(exp_d);
      qcnt_q     <= sat_count(total_d);
      play_out_q <= playing_d;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign done_o          = done_q;
  assign start_request_o = req_q;
  assign start_sound_o   = snd_q;
  assign dropped_full_o  = dropped_q;
  assign expired_count_o = expcnt_q;
  assign queue_count_o   = qcnt_q;
  assign head_playing_o  = play_out_q;

endmodule

`default_nettype wire

// File: rtl/epq_checker.sv
// port-level checks of the expiring play queue, bound to the top level
// uses epq_pkg for the mode codes
`default_nettype none

module epq_checker
  import epq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic [MODE_W-1:0]   mode_i,
  input wire logic                done_o,
  input wire logic                start_request_o,
  input wire logic [SOUND_W-1:0]  start_sound_o,
  input wire logic [COUNT_W-1:0]  queue_count_o,
  input wire logic                head_playing_o
);

  logic take;
  logic walk;

  assign take = start_i && !busy_o;
  assign walk = (mode_i == MODE_ENQUEUE) || (mode_i == MODE_PROCESS);

  // the result strobe marks the end of the work
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_short_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !walk) |=> (done_o && !busy_o))
    else $error("short command did not answer in one cycle");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && walk) |=> (busy_o && !done_o))
    else $error("enqueue or process did not go busy");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (mode_i == MODE_CLEAR)) |=> (queue_count_o == '0 && !head_playing_o))
    else $error("clear left entries or playing mark");

  a_no_offer_no_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !start_request_o) |-> (start_sound_o == '0))
    else $error("sound number without an offer");

endmodule

bind expiring_play_queue_top epq_checker u_epq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .mode_i         (mode_i),
  .done_o         (done_o),
  .start_request_o(start_request_o),
  .start_sound_o  (start_sound_o),
  .queue_count_o  (queue_count_o),
  .head_playing_o (head_playing_o)
);

`default_nettype wire
